>>> design/sdf_pkg.sv
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared types and defaults for the stream duplicate filter.
// ----------------------------------------------------------------------------
package sdf_pkg;

  // default number of distinct values held per batch
  localparam int unsigned SEEN_DEPTH_DEF = 64;

  // value width, fixed by the request fields
  localparam int unsigned VAL_W = 32;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture the accepted request, restart the scan
    logic rd_issue;  // read the store at the scan index, advance it
    logic finish;    // write the result, update the store
  } sdf_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last_issue;  // scan index points at the last valid entry
    logic hit;         // a stored entry matched so far
    logic count_zero;  // store is empty
    logic out_free;    // result register can take a result this cycle
  } sdf_sts_t;

endpackage

>>> design/sdf_ctrl.sv
// ----------------------------------------------------------------------------
// sdf_ctrl
// Sequencer: accept a request, scan the store one entry per cycle unless it is
// empty, then post the result once the result register is free.
// ----------------------------------------------------------------------------
module sdf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sdf_pkg::sdf_sts_t sts,
  output sdf_pkg::sdf_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // commands
  always_comb begin
    cmd          = '0;
    cmd.load     = in_valid && (state_r == ST_IDLE);
    cmd.rd_issue = (state_r == ST_SCAN) && !sts.hit;
    cmd.finish   = (state_r == ST_WRITE) && sts.out_free;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.count_zero ? ST_WRITE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        // a hit ends the scan early; later compares cannot change it
        if (sts.hit) begin
          state_nxt = ST_WRITE;
        end else if (sts.last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> design/sdf_dp.sv
// ----------------------------------------------------------------------------
// sdf_dp
// Datapath: request holding register, distinct-value store, scan compare
// and result register.
// ----------------------------------------------------------------------------
module sdf_dp #(
  parameter int unsigned SEEN_DEPTH = sdf_pkg::SEEN_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic signed [sdf_pkg::VAL_W-1:0]  in_value_in,
  input  logic                              in_batch_last,
  input  sdf_pkg::sdf_cmd_t                 cmd,
  output sdf_pkg::sdf_sts_t                 sts,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [sdf_pkg::VAL_W-1:0]  out_value_out,
  output logic                              out_kept,
  output logic                              out_overflow,
  output logic                              out_last_out
);

  localparam int unsigned AW = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
  localparam int unsigned CW = $clog2(SEEN_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(SEEN_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  // store of distinct values, valid below count_r
  logic [sdf_pkg::VAL_W-1:0] seen_mem [SEEN_DEPTH];

  logic [sdf_pkg::VAL_W-1:0] val_r;
  logic                      last_r;
  logic [CW-1:0]             count_r;
  logic [CW-1:0]             count_nxt;
  logic [AW-1:0]             idx_r;
  logic [sdf_pkg::VAL_W-1:0] rd_data_r;
  logic                      rd_vld_r;
  logic                      hit_r;
  logic                      hit_nxt;
  logic                      full;
  logic                      store_wr;
  logic                      out_valid_r;

  assign full     = (count_r == DEPTH_C);
  assign store_wr = cmd.finish && !hit_r && !full;

  // compare data read in the previous cycle
  assign hit_nxt = cmd.load ? 1'b0
                 : (hit_r || (rd_vld_r && (rd_data_r == val_r)));

  always_comb begin
    count_nxt = count_r;
    if (cmd.finish) begin
      if (last_r) begin
        count_nxt = '0;
      end else if (store_wr) begin
        count_nxt = count_r + ONE_C;
      end
    end
  end

  // status to the controller
  always_comb begin
    sts            = '0;
    sts.last_issue = ({1'b0, idx_r} == (count_r - ONE_C));
    sts.hit        = hit_r;
    sts.count_zero = (count_r == '0);
    sts.out_free   = !out_valid_r || out_ready;
  end

  // request holding register and scan index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r  <= in_value_in;
      last_r <= in_batch_last;
      idx_r  <= '0;
    end else if (cmd.rd_issue) begin
      idx_r  <= idx_r + AW'(1);
    end
  end

  // store write and registered read
  always_ff @(posedge clk) begin
    if (store_wr) begin
      seen_mem[count_r[AW-1:0]] <= val_r;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= seen_mem[idx_r];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      rd_vld_r <= 1'b0;
      hit_r    <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      rd_vld_r <= cmd.rd_issue;
      hit_r    <= hit_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_value_out <= val_r;
      out_kept      <= !hit_r;
      out_overflow  <= !hit_r && full;
      out_last_out  <= last_r;
    end
  end

  assign out_valid = out_valid_r;

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("store count beyond depth");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && last_r |=> count_r == '0)
    else $error("store not emptied after batch end");

  a_new_grows: assert property (@(posedge clk) disable iff (!rst_n)
    store_wr && !last_r |=> count_r == $past(count_r) + ONE_C)
    else $error("store count did not grow on new value");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |-> ({1'b0, idx_r} < count_r))
    else $error("scan read beyond valid entries");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> sts.out_free)
    else $error("result posted over a pending result");

endmodule

>>> design/stream_duplicate_filter.sv
// ----------------------------------------------------------------------------
// stream_duplicate_filter
// Keeps the first occurrence of each value in a batch; one result per request.
// ----------------------------------------------------------------------------
// Flow: each accepted request is compared with the distinct values stored in the
//   batch so far (no scan when the store is empty, early end on a hit), then its
//   result is posted once any earlier result has left the result register.
// One request at a time: a new one is accepted only after the last result is
//   posted; the scan reads one store entry per cycle through its single read port.
// Reset: synchronous, active low; empties the store and drops any pending result.
// ----------------------------------------------------------------------------
module stream_duplicate_filter #(
  parameter int unsigned SEEN_DEPTH = sdf_pkg::SEEN_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [sdf_pkg::VAL_W-1:0]  in_value_in,
  input  logic                              in_batch_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [sdf_pkg::VAL_W-1:0]  out_value_out,
  output logic                              out_kept,
  output logic                              out_overflow,
  output logic                              out_last_out
);

  sdf_pkg::sdf_cmd_t cmd;
  sdf_pkg::sdf_sts_t sts;

  // sequencer
  sdf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // store, compare and result register
  sdf_dp #(
    .SEEN_DEPTH (SEEN_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value_in   (in_value_in),
    .in_batch_last (in_batch_last),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value_out (out_value_out),
    .out_kept      (out_kept),
    .out_overflow  (out_overflow),
    .out_last_out  (out_last_out)
  );

endmodule

>>> tb/sdf_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_result_checker
// Watches the request and result channels of the duplicate filter. Every accepted
// request updates a local copy of the per-batch distinct-value store and
// queues the result it must produce. Every accepted result is compared field
// by field against the oldest queued one.
// ----------------------------------------------------------------------------
module sdf_result_checker #(
  parameter int unsigned SEEN_DEPTH = sdf_pkg::SEEN_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic signed [sdf_pkg::VAL_W-1:0]  in_value_in,
  input  logic                              in_batch_last,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [sdf_pkg::VAL_W-1:0]  out_value_out,
  input  logic                              out_kept,
  input  logic                              out_overflow,
  input  logic                              out_last_out,
  output int unsigned                       mismatch_count,
  output int unsigned                       pending_count,
  output int unsigned                       results_checked,
  output int unsigned                       kept_count,
  output int unsigned                       dropped_count,
  output int unsigned                       overflow_count
);

  typedef struct packed {
    logic signed [sdf_pkg::VAL_W-1:0] value;
    logic                             kept;
    logic                             overflow;
    logic                             last;
  } filter_result_t;

  // distinct values of the current batch, in arrival order
  logic [sdf_pkg::VAL_W-1:0] batch_seen [SEEN_DEPTH];
  int unsigned               batch_fill;
  filter_result_t            pending_results [$];
  filter_result_t            want;
  logic                      already_seen;
  int unsigned               errors;
  int unsigned               checked;
  int unsigned               n_kept;
  int unsigned               n_dropped;
  int unsigned               n_ovf;

  initial begin
    batch_fill = 0;
    errors     = 0;
    checked    = 0;
    n_kept     = 0;
    n_dropped  = 0;
    n_ovf      = 0;
    mismatch_count  = 0;
    pending_count   = 0;
    results_checked = 0;
    kept_count      = 0;
    dropped_count   = 0;
    overflow_count  = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      batch_fill = 0;
      pending_results.delete();
    end else begin
      // accepted request: look it up in the batch store, queue its result
      if (in_valid && in_ready) begin
        already_seen = 1'b0;
        for (int unsigned i = 0; i < batch_fill; i++) begin
          if (batch_seen[i] == in_value_in) already_seen = 1'b1;
        end
        want.value    = in_value_in;
        want.kept     = !already_seen;
        want.overflow = 1'b0;
        want.last     = in_batch_last;
        if (!already_seen) begin
          if (batch_fill < SEEN_DEPTH) begin
            batch_seen[batch_fill] = in_value_in;
            batch_fill++;
          end else begin
            // store full: new value passes but is not recorded
            want.overflow = 1'b1;
          end
        end
        if (in_batch_last) batch_fill = 0;
        pending_results.push_back(want);
      end

      // accepted result: compare with the oldest pending one
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result value=%0d kept=%0b overflow=%0b last=%0b",
                   $time, out_value_out, out_kept, out_overflow, out_last_out);
        end else begin
          want = pending_results.pop_front();
          checked++;
          if (want.kept) n_kept++;
          else n_dropped++;
          if (want.overflow) n_ovf++;
          if (out_value_out !== want.value) begin
            errors++;
            $display("%0t: value_out expected %0d actual %0d",
                     $time, want.value, out_value_out);
          end
          if (out_kept !== want.kept) begin
            errors++;
            $display("%0t: kept expected %0b actual %0b (value %0d)",
                     $time, want.kept, out_kept, want.value);
          end
          if (out_overflow !== want.overflow) begin
            errors++;
            $display("%0t: overflow expected %0b actual %0b (value %0d)",
                     $time, want.overflow, out_overflow, want.value);
          end
          if (out_last_out !== want.last) begin
            errors++;
            $display("%0t: last_out expected %0b actual %0b (value %0d)",
                     $time, want.last, out_last_out, want.value);
          end
        end
      end
    end

    mismatch_count  <= errors;
    pending_count   <= pending_results.size();
    results_checked <= checked;
    kept_count      <= n_kept;
    dropped_count   <= n_dropped;
    overflow_count  <= n_ovf;
  end

endmodule

>>> tb/tb_stream_duplicate_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stream_duplicate_filter
// Drives batches of signed values into the duplicate filter: a directed
// opening on extreme values and repeats, then random batches with heavy
// reuse of a small value pool, plus batches that fill the store and overflow.
// Both channels idle at random in phases one and two; the checker scores.
// ----------------------------------------------------------------------------
module tb_stream_duplicate_filter;

  localparam int unsigned DEPTH      = sdf_pkg::SEEN_DEPTH_DEF;
  localparam int unsigned N_REQUESTS = 1650;
  localparam int unsigned PHASE_LEN  = 550;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic signed [31:0]  in_value_in;
  logic                in_batch_last;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [31:0]  out_value_out;
  logic                out_kept;
  logic                out_overflow;
  logic                out_last_out;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned results_checked;
  int unsigned kept_count;
  int unsigned dropped_count;
  int unsigned overflow_count;

  int unsigned sender_idle_pct = 30;
  int unsigned sink_idle_pct   = 54;
  int unsigned requests_sent   = 0;
  int unsigned batches_sent    = 0;

  stream_duplicate_filter #(.SEEN_DEPTH(DEPTH)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value_in  (in_value_in),
    .in_batch_last(in_batch_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value_out(out_value_out),
    .out_kept     (out_kept),
    .out_overflow (out_overflow),
    .out_last_out (out_last_out)
  );

  sdf_result_checker #(.SEEN_DEPTH(DEPTH)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value_in    (in_value_in),
    .in_batch_last  (in_batch_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value_out  (out_value_out),
    .out_kept       (out_kept),
    .out_overflow   (out_overflow),
    .out_last_out   (out_last_out),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .results_checked(results_checked),
    .kept_count     (kept_count),
    .dropped_count  (dropped_count),
    .overflow_count (overflow_count)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // safety net against a hung handshake
  initial begin
    #8_000_000;
    $display("stream_duplicate_filter verification failed");
    $finish;
  end

  // one request: optional idle gap, then hold valid until accepted
  task automatic send_value(input logic signed [31:0] v, input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_value_in   <= v;
    in_batch_last <= last;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    requests_sent++;
    if (last) batches_sent++;
  endtask

  // one random batch; a fill batch runs the store full and past it
  task automatic send_batch(input bit fill_store);
    logic [31:0] pool_base;
    int unsigned len;
    int unsigned span;
    int unsigned extra;
    int unsigned pick;
    logic [31:0] v;
    pool_base = $urandom;
    if (fill_store || $urandom_range(19) == 0) begin
      for (int unsigned k = 0; k < DEPTH; k++) begin
        if (k > 0 && $urandom_range(7) == 0)
          send_value(pool_base + $urandom_range(k - 1), 1'b0);
        send_value(pool_base + k, 1'b0);
      end
      // mix of stored repeats, new values and repeats of unrecorded ones
      extra = $urandom_range(16, 4);
      for (int unsigned j = 0; j < extra; j++)
        send_value(pool_base + $urandom_range(DEPTH + 7), j == extra - 1);
    end else begin
      len  = $urandom_range(24, 1);
      span = $urandom_range(12, 1);
      for (int unsigned j = 0; j < len; j++) begin
        pick = $urandom_range(99);
        if (pick < 75) v = pool_base ^ $urandom_range(span);
        else if (pick < 90) v = $urandom;
        else begin
          case ($urandom_range(3))
            0: v = 32'h0;
            1: v = 32'hFFFF_FFFF;
            2: v = VAL_MIN;
            default: v = VAL_MAX;
          endcase
        end
        send_value(v, j == len - 1);
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    int unsigned quiet;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_value_in   = '0;
    in_batch_last = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // extremes, repeats of some, and a last marker on a repeat
    send_value(32'sd0,  1'b0);
    send_value(-32'sd1, 1'b0);
    send_value(VAL_MIN, 1'b0);
    send_value(VAL_MAX, 1'b0);
    send_value(32'sd0,  1'b0);
    send_value(VAL_MAX, 1'b0);
    send_value(32'sd1,  1'b0);
    send_value(VAL_MIN, 1'b1);
    // single-request batch: store cleared, so kept again
    send_value(VAL_MAX, 1'b1);
    // alternating bit patterns
    send_value(32'sh5555_5555, 1'b0);
    send_value(32'shAAAA_AAAA, 1'b0);
    send_value(32'sh5555_5555, 1'b0);
    send_value(32'shAAAA_AAAA, 1'b0);
    send_value(-32'sd1, 1'b1);
    // same value three times across a batch boundary
    send_value(32'sd7, 1'b1);
    send_value(32'sd7, 1'b0);
    send_value(32'sd7, 1'b1);

    // random part, first batch always fills the store and may run it into overflow
    send_batch(1'b1);
    while (requests_sent < N_REQUESTS) begin
      if (requests_sent >= 2 * PHASE_LEN) begin
        sender_idle_pct = 0;
        sink_idle_pct   = 0;
      end else if (requests_sent >= PHASE_LEN) begin
        sender_idle_pct = 54;
        sink_idle_pct   = 30;
      end
      send_batch(1'b0);
    end
    in_valid <= 1'b0;

    // let the checker count the last request, drain, then allow for a full
    // scan worth of extra cycles
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    quiet = DEPTH + 8;
    repeat (quiet) @(posedge clk);

    $display("Sent %0d requests in %0d batches; %0d results checked.",
             requests_sent, batches_sent, results_checked);
    $display("Results: %0d kept, %0d repeats dropped, %0d with store overflow.",
             kept_count, dropped_count, overflow_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("stream_duplicate_filter verification clean");
    end else begin
      $display("stream_duplicate_filter verification failed");
    end
    $finish;
  end

endmodule
